// ----- rtl/core/fec_pkg.sv -----
// Shared types and constants for the file event coalescer.
// No dependencies; imported by every module of the block.
package fec_pkg;

  // Change-rate table: TABLE_CAP + 1 slots
  localparam int TABLE_CAP = 4;
  localparam int SLOTS     = TABLE_CAP + 1;
  localparam int SLOT_W    = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [15:0] AGE_MAX     = 16'hFFFF;
  localparam logic [15:0] HOLD_RESET  = 16'd8000;
  localparam logic [15:0] DELAY_RESET = 16'd1000;
  localparam logic [15:0] COUNT_ONE   = 16'd1;

  // Input action codes
  localparam logic [2:0] ACT_ADDED    = 3'd0;
  localparam logic [2:0] ACT_REMOVED  = 3'd1;
  localparam logic [2:0] ACT_MODIFIED = 3'd2;
  localparam logic [2:0] ACT_OLD_NAME = 3'd3;
  localparam logic [2:0] ACT_NEW_NAME = 3'd4;

  // Result kinds
  localparam logic [1:0] KIND_REMOVED   = 2'd0;
  localparam logic [1:0] KIND_DIR_ADDED = 2'd1;
  localparam logic [1:0] KIND_CHANGED   = 2'd2;
  localparam logic [1:0] KIND_RENAMED   = 2'd3;

  // Configuration register indexes
  localparam logic CFG_CHANGE_HOLD  = 1'b0;
  localparam logic CFG_REMOVE_DELAY = 1'b1;

  typedef enum logic [2:0] {
    OP_TICK,
    OP_ADD,
    OP_REMOVE,
    OP_MODIFY,
    OP_OLD_NAME,
    OP_NEW_NAME,
    OP_STREAM
  } op_t;

  typedef struct packed {
    op_t         op;
    logic        first;
    logic [31:0] key;
  } cmd_t;

  typedef struct packed {
    logic [15:0] change_hold;
    logic [15:0] remove_delay;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] key;
    logic [31:0] from_key;
    logic        from_valid;
    logic        last;
  } res_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

endpackage

// ----- rtl/core/fec_front.sv -----
// Front end: accepts input transactions, classifies them into commands
// and queues them for the back end. Depends on fec_pkg.
module fec_front import fec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        func,
  input  logic [2:0]  action,
  input  logic [31:0] file_key,
  input  logic        first_of_batch,
  output head_t       head,
  input  logic        pop
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;
  cmd_t              cmd_in;
  logic              push;

  always_comb begin
    cmd_in.first = first_of_batch;
    cmd_in.key   = file_key;
    if (func) begin
      cmd_in.op = OP_TICK;
    end else begin
      case (action)
        ACT_ADDED:    cmd_in.op = OP_ADD;
        ACT_REMOVED:  cmd_in.op = OP_REMOVE;
        ACT_MODIFIED: cmd_in.op = OP_MODIFY;
        ACT_OLD_NAME: cmd_in.op = OP_OLD_NAME;
        ACT_NEW_NAME: cmd_in.op = OP_NEW_NAME;
        default:      cmd_in.op = OP_STREAM;
      endcase
    end
  end

  assign item_stall = (count == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign push       = item_valid && !item_stall;
  assign head.valid = (count != '0);
  assign head.cmd   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + {{QPTR_W{1'b0}}, push} - {{QPTR_W{1'b0}}, pop};
    end
  end

endmodule

// ----- rtl/core/fec_back.sv -----
// Back end: change-rate table, pending removal, held old name and the
// two-deep result buffer. Depends on fec_pkg.
module fec_back import fec_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  cfg_t  cfg,
  input  head_t head,
  output logic  pop,
  output logic  res_valid,
  input  logic  res_stall,
  output res_t  res
);

  typedef enum logic [1:0] {
    ST_LOOK = 2'b01,
    ST_EXEC = 2'b10
  } state_t;

  state_t state;

  // table
  logic [SLOTS-1:0] entry_valid;
  logic [31:0]      entry_key [SLOTS];
  logic [15:0]      entry_age [SLOTS];

  logic        remove_pending;
  logic [31:0] remove_key;
  logic [15:0] remove_countdown;
  logic        move_held;
  logic [31:0] move_key;

  // command and lookup results latched in ST_LOOK
  cmd_t              cmd;
  logic              hit;
  logic [SLOT_W-1:0] hit_idx;
  logic [15:0]       hit_age;
  logic [SLOT_W-1:0] ins_idx;

  logic              look_hit;
  logic [SLOT_W-1:0] look_idx;
  logic [15:0]       look_age;
  logic [SLOT_W-1:0] look_free;
  logic [SLOT_W-1:0] look_victim;
  logic [15:0]       best_age;

  res_t spare;
  logic spare_valid;

  logic look_go;
  logic exec_go;
  logic flush;
  logic emit;
  logic held;
  logic mod_pass;
  res_t act_res;
  res_t flush_res;

  always_comb begin
    look_hit  = 1'b0;
    look_idx  = '0;
    look_age  = '0;
    look_free = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (entry_valid[i] && entry_key[i] == head.cmd.key) begin
        look_hit = 1'b1;
        look_idx = SLOT_W'(i);
        look_age = entry_age[i];
      end
      if (!entry_valid[i]) begin
        look_free = SLOT_W'(i);
      end
    end
    // oldest entry, lowest slot on a tie
    look_victim = '0;
    best_age    = entry_age[0];
    for (int i = 1; i < SLOTS; i++) begin
      if (entry_age[i] > best_age) begin
        best_age    = entry_age[i];
        look_victim = SLOT_W'(i);
      end
    end
  end

  assign look_go = (state == ST_LOOK) && head.valid;
  assign exec_go = (state == ST_EXEC) && !res_valid && !spare_valid;
  assign pop     = look_go;

  always_comb begin
    held     = move_held && !cmd.first;
    mod_pass = !hit || (hit_age > cfg.change_hold) || (hit_age == AGE_MAX);
    if (cmd.op == OP_TICK) begin
      flush = remove_pending && (remove_countdown <= COUNT_ONE);
    end else begin
      flush = remove_pending && !(cmd.op == OP_OLD_NAME && cmd.key == remove_key);
    end

    act_res.key        = cmd.key;
    act_res.from_key   = '0;
    act_res.from_valid = 1'b0;
    act_res.last       = 1'b1;
    case (cmd.op)
      OP_ADD: begin
        emit          = 1'b1;
        act_res.kind  = KIND_DIR_ADDED;
        act_res.key   = '0;
      end
      OP_MODIFY: begin
        emit          = mod_pass;
        act_res.kind  = KIND_CHANGED;
      end
      OP_NEW_NAME: begin
        emit               = 1'b1;
        act_res.kind       = KIND_RENAMED;
        act_res.from_key   = held ? move_key : '0;
        act_res.from_valid = held;
      end
      default: begin
        emit          = 1'b0;
        act_res.kind  = KIND_REMOVED;
      end
    endcase

    flush_res.kind       = KIND_REMOVED;
    flush_res.key        = remove_key;
    flush_res.from_key   = '0;
    flush_res.from_valid = 1'b0;
    flush_res.last       = !emit;
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (look_go) begin
      cmd     <= head.cmd;
      hit     <= look_hit;
      hit_idx <= look_idx;
      hit_age <= look_age;
      ins_idx <= (&entry_valid) ? look_victim : look_free;
    end
    if (res_valid && !res_stall) begin
      res <= spare;
    end
    if (exec_go) begin
      res   <= flush ? flush_res : act_res;
      spare <= act_res;
      if (cmd.op == OP_TICK) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (entry_valid[i] && entry_age[i] != AGE_MAX) begin
            entry_age[i] <= entry_age[i] + 1'b1;
          end
        end
      end else if (cmd.op == OP_MODIFY) begin
        if (!hit) begin
          entry_key[ins_idx] <= cmd.key;
          entry_age[ins_idx] <= '0;
        end else if (mod_pass) begin
          entry_age[hit_idx] <= '0;
        end
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_LOOK;
      entry_valid      <= '0;
      remove_pending   <= 1'b0;
      remove_key       <= '0;
      remove_countdown <= '0;
      move_held        <= 1'b0;
      move_key         <= '0;
      res_valid        <= 1'b0;
      spare_valid      <= 1'b0;
    end else begin
      if (res_valid && !res_stall) begin
        res_valid   <= spare_valid;
        spare_valid <= 1'b0;
      end
      case (state)
        ST_LOOK: begin
          if (look_go) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (exec_go) begin
            state       <= ST_LOOK;
            res_valid   <= flush || emit;
            spare_valid <= flush && emit;
            if (cmd.op == OP_TICK) begin
              if (flush) begin
                remove_pending   <= 1'b0;
                remove_key       <= '0;
                remove_countdown <= '0;
              end else if (remove_pending) begin
                remove_countdown <= remove_countdown - 1'b1;
              end
            end else begin
              // table update
              if (cmd.op == OP_MODIFY) begin
                if (!hit) begin
                  entry_valid[ins_idx] <= 1'b1;
                end
              end else if (hit) begin
                entry_valid[hit_idx] <= 1'b0;
              end
              // any event resolves a pending removal (dropped or sent)
              if (cmd.op == OP_REMOVE) begin
                remove_pending   <= 1'b1;
                remove_key       <= cmd.key;
                remove_countdown <= cfg.remove_delay;
              end else if (remove_pending) begin
                remove_pending   <= 1'b0;
                remove_key       <= '0;
                remove_countdown <= '0;
              end
              // held old name
              if (cmd.op == OP_OLD_NAME) begin
                move_held <= 1'b1;
                move_key  <= cmd.key;
              end else if (cmd.op == OP_NEW_NAME) begin
                move_held <= 1'b0;
                move_key  <= '0;
              end else if (cmd.first) begin
                move_held <= 1'b0;
              end
            end
          end
        end
        default: state <= ST_LOOK;
      endcase
    end
  end

endmodule

// ----- rtl/core/file_event_coalescer_top.sv -----
// Top level of the file event coalescer: configuration registers and the
// front end / back end pair. Depends on fec_pkg, fec_front, fec_back.
//
//   channel   direction  handshake               payload
//   item      in         item_valid/item_stall   func, action, file_key, first_of_batch
//   result    out        res_valid/res_stall     kind, key_out, from_key, from_valid, last
//   config    in         cfg_wen                 cfg_index, cfg_wdata
//
// Flow: the back end handles each command as a table lookup, then an execute
// step, and the next lookup overlaps the first result leaving. The execute
// step waits until the two-deep result buffer is empty, so a command is only
// executed once the earlier results have left, which res_stall can hold back.
// The front end queues up to 4 commands, so items are taken while results wait.
// Reset: synchronous; empties the queue, the table valid bits, the pending
// removal and held old name, and loads 8000 / 1000 into the config registers.
// Stalls: item_stall is high only while the command queue is full.
module file_event_coalescer_top import fec_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        func,
  input  logic [2:0]  action,
  input  logic [31:0] file_key,
  input  logic        first_of_batch,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  kind,
  output logic [31:0] key_out,
  output logic [31:0] from_key,
  output logic        from_valid,
  output logic        last,
  input  logic        cfg_wen,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata
);

  cfg_t  cfg;
  head_t head;
  logic  pop;
  res_t  res;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.change_hold  <= HOLD_RESET;
      cfg.remove_delay <= DELAY_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_CHANGE_HOLD:  cfg.change_hold  <= cfg_wdata;
        CFG_REMOVE_DELAY: cfg.remove_delay <= cfg_wdata;
        default:          cfg.change_hold  <= cfg.change_hold;
      endcase
    end
  end

  fec_front u_front (
    .clk            (clk),
    .rst            (rst),
    .item_valid     (item_valid),
    .item_stall     (item_stall),
    .func           (func),
    .action         (action),
    .file_key       (file_key),
    .first_of_batch (first_of_batch),
    .head           (head),
    .pop            (pop)
  );

  fec_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  assign kind       = res.kind;
  assign key_out    = res.key;
  assign from_key   = res.from_key;
  assign from_valid = res.from_valid;
  assign last       = res.last;

endmodule
